/* rtl/pfe_pkg.sv */
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types and constants of the byte pipe with end counts.
// ----------------------------------------------------------------------------
package pfe_pkg;

   localparam int DEPTH    = 4096;
   localparam int MAX_ENDS = 255;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int LEVEL_W  = $clog2(DEPTH + 1);
   localparam int END_W    = $clog2(MAX_ENDS + 1);
   localparam int BYTE_W   = 8;
   localparam int REQ_W    = 16;
   localparam int RSP_W    = 24;

   typedef enum logic [2:0] {
      FUNC_WRITE        = 3'd0,
      FUNC_READ         = 3'd1,
      FUNC_OPEN_READER  = 3'd2,
      FUNC_CLOSE_READER = 3'd3,
      FUNC_OPEN_WRITER  = 3'd4,
      FUNC_CLOSE_WRITER = 3'd5,
      FUNC_CREATE       = 3'd6
   } func_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_WAIT_EMPTY = 3'd1,
      ST_EOF        = 3'd2,
      ST_WAIT_FULL  = 3'd3,
      ST_BROKEN     = 3'd4,
      ST_REQ_ERR    = 3'd5
   } status_type;

   typedef struct packed {
      logic              we;
      logic              re;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] wdata;
   } mem_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [LEVEL_W-1:0] level;
      logic               call_done;
      logic               rd_ok;
   } result_type;

endpackage

/* rtl/pipe_byte_fifo_with_end_counts.sv */
// ----------------------------------------------------------------------------
// pipe_byte_fifo_with_end_counts
// Byte pipe: a ring buffer in a block RAM with open read and write end counts.
// ----------------------------------------------------------------------------
// Each request item on the req_ channel carries a function code and a byte.
// It creates the pipe, writes or reads one byte, or opens or closes a read
// or write end. Exactly one response item per request leaves on the rsp_
// channel, with the byte read, a status, the buffer level after the request
// and the echoed end-of-call mark on tlast.
// A request is decoded and the pointers and counts are updated in the cycle
// it is accepted; the store is read in that same cycle and the response item
// appears in the output register on the next cycle.
// One request item is taken every cycle as long as the response side takes
// its items; the single output register sets that figure. While a response
// waits unaccepted, req_tready is low and the state and output hold.
// Reset clears the pointers, the fill count, both end counts and the output
// valid and holds req_tready low; the byte store keeps its contents and needs
// no clearing pass.
// ----------------------------------------------------------------------------
module pipe_byte_fifo_with_end_counts (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [pfe_pkg::REQ_W-1:0]   req_tdata,  // func[2:0], wdata[10:3], zero
   input  logic                        req_tlast,  // last_byte
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [pfe_pkg::RSP_W-1:0]   rsp_tdata,  // rdata[7:0], status[10:8], level[23:11]
   output logic                        rsp_tlast   // call_done
);
   import pfe_pkg::*;

   logic               accept;
   mem_req_type        mem_req;
   result_type         result;
   logic [BYTE_W-1:0]  ram_rdata;

   logic               rsp_valid_ff;
   result_type         rsp_result_ff;

   assign req_tready = ~reset & (~rsp_valid_ff | rsp_tready);
   assign accept     = req_tvalid & req_tready;

   pfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (req_tdata[2:0]),
      .wdata     (req_tdata[10:3]),
      .last_byte (req_tlast),
      .mem_req   (mem_req),
      .result    (result)
   );

   pfe_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_tready) begin
         rsp_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_result_ff.level, rsp_result_ff.status,
                        rsp_result_ff.rd_ok ? ram_rdata : {BYTE_W{1'b0}}};
   assign rsp_tlast  = rsp_result_ff.call_done;

endmodule

/* rtl/pfe_ram.sv */
// ----------------------------------------------------------------------------
// pfe_ram
// Single-port byte store with a registered read port.
// ----------------------------------------------------------------------------
module pfe_ram (
   input  logic                         clock,
   input  pfe_pkg::mem_req_type         mem_req,
   output logic [pfe_pkg::BYTE_W-1:0]   rdata
);
   import pfe_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= mem[mem_req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/pfe_ctrl.sv */
// ----------------------------------------------------------------------------
// pfe_ctrl
// Pointer and end-count state, request decode and store access generation.
// ----------------------------------------------------------------------------
module pfe_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [2:0]                   func,
   input  logic [pfe_pkg::BYTE_W-1:0]   wdata,
   input  logic                         last_byte,
   output pfe_pkg::mem_req_type         mem_req,
   output pfe_pkg::result_type          result
);
   import pfe_pkg::*;

   logic [ADDR_W-1:0]  read_index_ff, read_index_in;
   logic [LEVEL_W-1:0] fill_count_ff, fill_count_in;
   logic [END_W-1:0]   reader_count_ff, reader_count_in;
   logic [END_W-1:0]   writer_count_ff, writer_count_in;

   logic [LEVEL_W:0]   wpos_sum;
   logic [ADDR_W-1:0]  wpos;
   logic [ADDR_W-1:0]  rnext;
   logic [2:0]         status;
   logic               rd_ok;
   logic               wr_ok;

   always_comb begin
      wpos_sum = {1'b0, fill_count_ff} + (LEVEL_W + 1)'(read_index_ff);
      if (wpos_sum >= (LEVEL_W + 1)'(DEPTH)) begin
         wpos = ADDR_W'(wpos_sum - (LEVEL_W + 1)'(DEPTH));
      end else begin
         wpos = ADDR_W'(wpos_sum);
      end
      if (read_index_ff == ADDR_W'(DEPTH - 1)) begin
         rnext = '0;
      end else begin
         rnext = read_index_ff + ADDR_W'(1);
      end
   end

   always_comb begin
      read_index_in   = read_index_ff;
      fill_count_in   = fill_count_ff;
      reader_count_in = reader_count_ff;
      writer_count_in = writer_count_ff;
      status          = ST_REQ_ERR;
      rd_ok           = 1'b0;
      wr_ok           = 1'b0;
      case (func)
         FUNC_WRITE: begin
            if (reader_count_ff == '0) begin
               status = ST_BROKEN;
            end else if (fill_count_ff >= LEVEL_W'(DEPTH)) begin
               status = ST_WAIT_FULL;
            end else begin
               wr_ok         = 1'b1;
               fill_count_in = fill_count_ff + LEVEL_W'(1);
               status        = ST_OK;
            end
         end
         FUNC_READ: begin
            if (fill_count_ff == '0) begin
               status = (writer_count_ff == '0) ? ST_EOF : ST_WAIT_EMPTY;
            end else begin
               rd_ok         = 1'b1;
               read_index_in = rnext;
               fill_count_in = fill_count_ff - LEVEL_W'(1);
               status        = ST_OK;
            end
         end
         FUNC_OPEN_READER: begin
            if (reader_count_ff < END_W'(MAX_ENDS)) begin
               reader_count_in = reader_count_ff + END_W'(1);
               status          = ST_OK;
            end
         end
         FUNC_CLOSE_READER: begin
            if (reader_count_ff != '0) begin
               reader_count_in = reader_count_ff - END_W'(1);
               status          = ST_OK;
               if (reader_count_in == '0 && writer_count_ff == '0) begin
                  fill_count_in = '0;
                  read_index_in = '0;
               end
            end
         end
         FUNC_OPEN_WRITER: begin
            if (writer_count_ff < END_W'(MAX_ENDS)) begin
               writer_count_in = writer_count_ff + END_W'(1);
               status          = ST_OK;
            end
         end
         FUNC_CLOSE_WRITER: begin
            if (writer_count_ff != '0) begin
               writer_count_in = writer_count_ff - END_W'(1);
               status          = ST_OK;
               if (writer_count_in == '0 && reader_count_ff == '0) begin
                  fill_count_in = '0;
                  read_index_in = '0;
               end
            end
         end
         FUNC_CREATE: begin
            fill_count_in   = '0;
            read_index_in   = '0;
            reader_count_in = END_W'(1);
            writer_count_in = END_W'(1);
            status          = ST_OK;
         end
         default: begin
            status = ST_REQ_ERR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_index_ff   <= '0;
         fill_count_ff   <= '0;
         reader_count_ff <= '0;
         writer_count_ff <= '0;
      end else if (accept) begin
         read_index_ff   <= read_index_in;
         fill_count_ff   <= fill_count_in;
         reader_count_ff <= reader_count_in;
         writer_count_ff <= writer_count_in;
      end
   end

   always_comb begin
      mem_req.we     = accept & wr_ok;
      mem_req.re     = accept & rd_ok;
      mem_req.addr   = wr_ok ? wpos : read_index_ff;
      mem_req.wdata  = wdata;
      result.status    = status;
      result.level     = fill_count_in;
      result.call_done = last_byte;
      result.rd_ok     = rd_ok;
   end

endmodule
